FILE: rtl/base64_stream_encoder_top_defines.svh
// Assertion macros for the base64 stream encoder checker.
// Used by b64se_checker; expects clock and reset in scope.
`ifndef BASE64_STREAM_ENCODER_TOP_DEFINES_SVH
`define BASE64_STREAM_ENCODER_TOP_DEFINES_SVH

// Check that cons holds in the cycle after ante.
`define B64SE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("b64se port check failed");

// Check that cons holds in the same cycle as ante.
`define B64SE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("b64se port check failed");

`endif

FILE: rtl/b64se_pkg.sv
// Shared types, constants and the sextet-to-ASCII function of the base64 encoder.
// No dependencies.
`timescale 1ns / 1ps
package b64se_pkg;

   localparam logic [6:0] PAD_CHAR = 7'h3D;
   localparam logic [1:0] LAST_IDX = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [6:0] ascii_char;
      logic       group_end;
      logic       message_end;
   } rsp_type;

   typedef struct packed {
      logic [23:0] word;
      logic [1:0]  total;
      logic        fin;
   } grp_type;

   function automatic logic [6:0] sextet_char(input logic [5:0] s);
      logic [6:0] c;
      if (s < 6'd26) begin
         c = 7'h41 + {1'b0, s};
      end else if (s < 6'd52) begin
         c = 7'h61 + {1'b0, s} - 7'd26;
      end else if (s < 6'd62) begin
         c = 7'h30 + {1'b0, s} - 7'd52;
      end else if (s == 6'd62) begin
         c = 7'h2B;
      end else begin
         c = 7'h2F;
      end
      return c;
   endfunction

endpackage

FILE: rtl/b64se_front.sv
// Front stage: gathers bytes into three-byte groups and hands off full or final groups.
// Depends on b64se_pkg.
`timescale 1ns / 1ps
module b64se_front
   import b64se_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_item,
   output logic    grp_push,
   output grp_type grp_data
);

   logic [15:0] pend_ff, pend_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [23:0] word;
   logic [1:0]  total;

   always_comb begin
      case (cnt_ff)
         2'd0: begin
            word = {in_item.data_byte, 16'h0000};
         end
         2'd1: begin
            word = {pend_ff[15:8], in_item.data_byte, 8'h00};
         end
         default: begin
            word = {pend_ff, in_item.data_byte};
         end
      endcase
      total = (cnt_ff == 2'd0) ? 2'd1 : ((cnt_ff == 2'd1) ? 2'd2 : 2'd3);

      pend_in          = pend_ff;
      cnt_in           = cnt_ff;
      grp_push         = 1'b0;
      grp_data.word    = word;
      grp_data.total   = total;
      grp_data.fin     = in_item.final_byte;
      if (in_valid) begin
         if (total != 2'd3 && !in_item.final_byte) begin
            pend_in = word[23:8];
            cnt_in  = total;
         end else begin
            grp_push = 1'b1;
            pend_in  = 16'h0000;
            cnt_in   = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         pend_ff <= 16'h0000;
      end else begin
         cnt_ff  <= cnt_in;
         pend_ff <= pend_in;
      end
   end

endmodule

FILE: rtl/b64se_queue.sv
// Short group queue between the front and back stages.
// Depends on b64se_pkg.
`timescale 1ns / 1ps
module b64se_queue
   import b64se_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  grp_type push_data,
   input  logic    pop,
   output grp_type pop_data,
   output logic    full,
   output logic    empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   grp_type         slot_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign full     = (cnt_ff == FULL_CNT);
   assign empty    = (cnt_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/b64se_back.sv
// Back stage: one group to four characters in an output register, one per cycle unless stalled.
// Depends on b64se_pkg.
`timescale 1ns / 1ps
module b64se_back
   import b64se_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  grp_type q_data,
   output logic    q_pop,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_take
);

   grp_type    grp_ff;
   logic       grp_valid_ff, grp_valid_in;
   logic [1:0] idx_ff, idx_in;
   rsp_type    out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   logic       advance;
   logic       need_grp;
   logic [5:0] sextet;
   logic       pad;

   assign advance   = !out_valid_ff || out_take;
   assign need_grp  = !grp_valid_ff || (advance && idx_ff == LAST_IDX);
   assign q_pop     = need_grp && !q_empty;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   always_comb begin
      case (idx_ff)
         2'd0: begin
            sextet = grp_ff.word[23:18];
            pad    = 1'b0;
         end
         2'd1: begin
            sextet = grp_ff.word[17:12];
            pad    = 1'b0;
         end
         2'd2: begin
            sextet = grp_ff.word[11:6];
            pad    = (grp_ff.total < 2'd2);
         end
         default: begin
            sextet = grp_ff.word[5:0];
            pad    = (grp_ff.total < 2'd3);
         end
      endcase

      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      grp_valid_in = grp_valid_ff;
      idx_in       = idx_ff;
      if (advance) begin
         out_valid_in = grp_valid_ff;
         if (grp_valid_ff) begin
            out_in.ascii_char  = pad ? PAD_CHAR : sextet_char(sextet);
            out_in.group_end   = (idx_ff == LAST_IDX);
            out_in.message_end = (idx_ff == LAST_IDX) && grp_ff.fin;
            idx_in             = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               grp_valid_in = 1'b0;
            end
         end
      end
      if (q_pop) begin
         grp_valid_in = 1'b1;
         idx_in       = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         grp_valid_ff <= grp_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (q_pop) begin
         grp_ff <= q_data;
      end
   end

endmodule

FILE: rtl/base64_stream_encoder_top.sv
// Top level of the byte-serial base64 encoder.
// Depends on b64se_pkg, b64se_front, b64se_queue and b64se_back.
//
// Takes one message byte per beat and returns standard-alphabet base64 characters one per
// beat, '=' padded, with group_end on every fourth character and message_end on the last.
// A byte is taken every cycle while the group queue has room; the back stage sends the four
// characters of a group one at a time and holds each until it is popped, so on a long stream
// the single character path sets the byte rate. A byte that closes a group passes through the
// group queue and the back stage's group register before its first character is output.
`timescale 1ns / 1ps
module base64_stream_encoder_top
   import b64se_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic    q_full;
   logic    q_empty;
   logic    q_pop;
   logic    grp_push;
   grp_type grp_data;
   grp_type q_data;
   logic    out_valid;

   assign req_full  = q_full;
   assign rsp_empty = !out_valid;

   b64se_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_push && !q_full),
      .in_item  (req_data),
      .grp_push (grp_push),
      .grp_data (grp_data)
   );

   b64se_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (grp_push),
      .push_data (grp_data),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   b64se_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .out_valid (out_valid),
      .out_data  (rsp_data),
      .out_take  (rsp_pop)
   );

endmodule

FILE: rtl/b64se_checker.sv
// Port-level checks for the base64 encoder, bound to the top level.
// Depends on b64se_pkg and base64_stream_encoder_top_defines.svh.
`timescale 1ns / 1ps
`include "base64_stream_encoder_top_defines.svh"
module b64se_checker
   import b64se_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   `B64SE_ASSERT_NEXT(a_rsp_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data))
   `B64SE_ASSERT_NOW(a_msg_end_group, !rsp_empty && rsp_data.message_end, rsp_data.group_end)
   `B64SE_ASSERT_NOW(a_pad_last,
      !rsp_empty && rsp_data.group_end && rsp_data.ascii_char == PAD_CHAR, rsp_data.message_end)
   `B64SE_ASSERT_NOW(a_reset_empty, $past(reset), rsp_empty)

endmodule

bind base64_stream_encoder_top b64se_checker u_checker (.*);

FILE: test/encoded_char_checker.sv
// Checker for the base64 stream encoder: watches both queue ports, predicts each character.
// Depends on b64se_pkg for the beat types and the pad character.
`timescale 1ns / 1ps
module encoded_char_checker
   import b64se_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  logic    req_full,
   input  req_type req_data,
   input  logic    rsp_empty,
   input  logic    rsp_pop,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      chars_outstanding
);

   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   logic [15:0] held_bytes;
   logic [1:0]  held_count;
   rsp_type     expected_chars[$];
   rsp_type     want;

   function automatic logic [6:0] b64_symbol(input logic [5:0] idx);
      return ALPHABET[8 * (63 - int'(idx)) +: 7];
   endfunction

   task automatic queue_char(input logic [6:0] ch, input logic gend, input logic mend);
      rsp_type entry;
      entry.ascii_char  = ch;
      entry.group_end   = gend;
      entry.message_end = mend;
      expected_chars.insert(expected_chars.size(), entry);
   endtask

   task automatic encode_byte(input req_type beat);
      logic [23:0] group;
      logic [1:0]  filled;
      case (held_count)
         2'd0: begin
            group = {beat.data_byte, 16'h0000};
         end
         2'd1: begin
            group = {held_bytes[15:8], beat.data_byte, 8'h00};
         end
         default: begin
            group = {held_bytes, beat.data_byte};
         end
      endcase
      filled = held_count + 2'd1;
      if (filled < 2'd3 && !beat.final_byte) begin
         held_bytes = group[23:8];
         held_count = filled;
      end else begin
         queue_char(b64_symbol(group[23:18]), 1'b0, 1'b0);
         queue_char(b64_symbol(group[17:12]), 1'b0, 1'b0);
         queue_char((filled >= 2'd2) ? b64_symbol(group[11:6]) : PAD_CHAR, 1'b0, 1'b0);
         queue_char((filled == 2'd3) ? b64_symbol(group[5:0]) : PAD_CHAR,
                    1'b1, beat.final_byte);
         held_bytes = 16'h0000;
         held_count = 2'd0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_bytes = 16'h0000;
         held_count = 2'd0;
         expected_chars.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_chars.size() == 0) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10) begin
                  $display("%0t: unexpected char %h group_end %b message_end %b", $realtime,
                           rsp_data.ascii_char, rsp_data.group_end, rsp_data.message_end);
               end
            end else begin
               want = expected_chars.pop_front();
               if (want.ascii_char !== rsp_data.ascii_char ||
                   want.group_end !== rsp_data.group_end ||
                   want.message_end !== rsp_data.message_end) begin
                  fail_count = fail_count + 1;
                  if (fail_count <= 10) begin
                     $display("%0t: char exp %h/%b/%b got %h/%b/%b", $realtime,
                              want.ascii_char, want.group_end, want.message_end,
                              rsp_data.ascii_char, rsp_data.group_end, rsp_data.message_end);
                  end
               end
            end
         end
         if (req_push && !req_full) begin
            encode_byte(req_data);
         end
      end
      chars_outstanding = expected_chars.size();
   end

endmodule

FILE: test/tb.sv
// Testbench top for the base64 stream encoder: clock, reset, byte stimulus and verdict.
// Depends on b64se_pkg, base64_stream_encoder_top and encoded_char_checker.
`timescale 1ns / 1ps
module tb;
   import b64se_pkg::*;

   localparam int HOLD_CYCLES = 200;
   localparam int STALL_LIMIT = 4000;
   localparam int DIR_MSGS = 7;
   localparam int DIR_COUNT = 19;

   localparam int DIR_LEN[DIR_MSGS] = '{1, 1, 2, 2, 3, 6, 4};
   localparam logic [7:0] DIR_BYTES[DIR_COUNT] = '{
      8'h00,
      8'hFF,
      8'h00, 8'h00,
      8'hFF, 8'hFF,
      8'h4D, 8'h61, 8'h6E,
      8'hFB, 8'hEF, 8'hBE, 8'hF8, 8'h00, 8'h10,
      8'hFF, 8'hFF, 8'hFF, 8'h01
   };

   logic    clock = 1'b0;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;
   int      fail_count;
   int      chars_outstanding;
   int      send_idle_pct;
   int      recv_idle_pct;
   bit      rsp_hold;
   int      quiet_cycles;

   always #5 clock = ~clock;

   base64_stream_encoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   encoded_char_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_data          (req_data),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_data          (rsp_data),
      .fail_count        (fail_count),
      .chars_outstanding (chars_outstanding)
   );

   task automatic push_byte(input logic [7:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= '{value, last};
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         push_byte(8'($urandom), i == len - 1);
      end
   endtask

   task automatic send_phase(input int byte_budget);
      int sent;
      int len;
      sent = 0;
      while (sent < byte_budget) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
         send_message(len);
         sent += len;
      end
   endtask

   // receiver: random pops, or a long hold-off when asked
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold && !hold_done) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int idx;
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      rsp_hold = 1'b0;
      send_idle_pct = 19;
      recv_idle_pct = 54;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      idx = 0;
      for (int m = 0; m < DIR_MSGS; m++) begin
         for (int i = 0; i < DIR_LEN[m]; i++) begin
            push_byte(DIR_BYTES[idx], i == DIR_LEN[m] - 1);
            idx++;
         end
      end

      // fill the block while the receiver holds off
      rsp_hold = 1'b1;
      send_message(30);
      send_phase(120);

      // hold until every char is out
      req_push <= 1'b0;
      wait (chars_outstanding == 0);
      @(negedge clock);

      send_idle_pct = 54;
      recv_idle_pct = 19;
      send_phase(130);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_phase(130);

      req_push <= 1'b0;
      wait (chars_outstanding == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && chars_outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
